>>> design/stx_lcfp_pkg.sv
// Shared constants, types and command/status structs of the frame parser.
`default_nettype none

package stx_lcfp_pkg;

    // Payload store size and derived widths
    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int POS_W       = 6;
    localparam int IDX_W       = 1;

    // Register reset values
    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h02;
    localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'h03;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_START_BYTE = 1'd0,
        REG_END_BYTE   = 1'd1
    } reg_idx_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_START      = 3'd0,
        ST_LENGTH     = 3'd1,
        ST_FILL       = 3'd2,
        ST_CHECK      = 3'd3,
        ST_END        = 3'd4,
        ST_DRAIN_READ = 3'd5,
        ST_DRAIN_LOAD = 3'd6
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_length;
        logic take_fill;
        logic start_drain;
        logic load_out;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic rx_is_start;
        logic length_ok;
        logic fill_done;
        logic sum_match;
        logic end_match;
        logic length_zero;
        logic out_free;
        logic drain_last;
    } status_t;

endpackage

`default_nettype wire

>>> design/stx_lcfp_rx_if.sv
// Received-byte channel: valid/ready handshake carrying one byte.
`default_nettype none

interface stx_lcfp_rx_if
    import stx_lcfp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> design/stx_lcfp_pl_if.sv
// Payload channel: valid/ready handshake carrying one validated payload byte.
`default_nettype none

interface stx_lcfp_pl_if
    import stx_lcfp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic [POS_W-1:0]  byte_position;
    logic              frame_last;

    modport source (output valid, output payload_byte, output byte_position,
                    output frame_last, input ready);
    modport sink (input valid, input payload_byte, input byte_position,
                  input frame_last, output ready);
endinterface

`default_nettype wire

>>> design/stx_lcfp_ctrl.sv
// Frame parser controller: phase state machine and command generation.
`default_nettype none

module stx_lcfp_ctrl
    import stx_lcfp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t sts,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_START:
            begin
                in_ready = 1'b1;
                if (in_valid && sts.rx_is_start)
                begin
                    state_next = ST_LENGTH;
                end
            end
            ST_LENGTH:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_length = 1'b1;
                    if (sts.length_ok)
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_fill = 1'b1;
                    if (sts.fill_done)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = sts.sum_match ? ST_END : ST_START;
                end
            end
            ST_END:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.end_match && !sts.length_zero)
                    begin
                        cmd.start_drain = 1'b1;
                        state_next      = ST_DRAIN_READ;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_DRAIN_READ:
            begin
                // wait for the store read data
                state_next = ST_DRAIN_LOAD;
            end
            ST_DRAIN_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = sts.drain_last ? ST_START : ST_DRAIN_READ;
                end
            end
            default:
            begin
                state_next = ST_START;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/stx_lcfp_dp.sv
// Frame parser datapath: config registers, counters, checksum, store, output register.
`default_nettype none

module stx_lcfp_dp
    import stx_lcfp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_index,
    input  wire logic [BYTE_W-1:0] wr_data,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire cmd_t              cmd,
    output status_t                sts,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [BYTE_W-1:0]      out_byte,
    output logic [POS_W-1:0]       out_pos,
    output logic                   out_last
);

    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] end_byte_reg;
    logic [LEN_W-1:0]  frame_length_reg;
    logic [LEN_W-1:0]  bytes_taken_reg;
    logic [LEN_W-1:0]  bytes_taken_next;
    logic [BYTE_W-1:0] running_sum_reg;
    logic [LEN_W-1:0]  rd_idx_reg;
    logic [LEN_W-1:0]  rd_idx_inc;
    logic [ADDR_W-1:0] fill_slot;
    logic [BYTE_W-1:0] store_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_last_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RESET;
            end_byte_reg   <= END_BYTE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_START_BYTE: start_byte_reg <= wr_data;
                REG_END_BYTE:   end_byte_reg   <= wr_data;
                default:        ;
            endcase
        end
    end

    // Count, slot and read index arithmetic
    assign bytes_taken_next = bytes_taken_reg + LEN_W'(1);
    assign rd_idx_inc       = rd_idx_reg + LEN_W'(1);
    assign fill_slot        = (bytes_taken_reg >= LEN_W'(MAX_PAYLOAD))
                              ? ADDR_W'(MAX_PAYLOAD - 1)
                              : bytes_taken_reg[ADDR_W-1:0];

    // Frame length, fill count and checksum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= '0;
            bytes_taken_reg  <= '0;
            running_sum_reg  <= '0;
        end
        else if (cmd.take_length)
        begin
            bytes_taken_reg <= '0;
            running_sum_reg <= '0;
            if (sts.length_ok)
            begin
                frame_length_reg <= LEN_W'(rx_byte);
            end
        end
        else if (cmd.take_fill)
        begin
            bytes_taken_reg <= bytes_taken_next;
            if (bytes_taken_reg < frame_length_reg)
            begin
                running_sum_reg <= running_sum_reg + rx_byte;
            end
        end
    end

    // Payload store: write while filling, registered read at the drain index
    always_ff @(posedge clk)
    begin
        if (cmd.take_fill)
        begin
            store_mem[fill_slot] <= rx_byte;
        end
        rd_data_reg <= store_mem[rd_idx_reg[ADDR_W-1:0]];
    end

    // Drain index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.start_drain)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.load_out)
        begin
            rd_idx_reg <= rd_idx_inc;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_byte_reg <= rd_data_reg;
            out_pos_reg  <= rd_idx_reg[POS_W-1:0];
            out_last_reg <= sts.drain_last;
        end
    end

    // Status to controller
    always_comb
    begin
        sts.rx_is_start = (rx_byte == start_byte_reg);
        sts.length_ok   = (rx_byte <= BYTE_W'(MAX_PAYLOAD));
        sts.fill_done   = (bytes_taken_next >= frame_length_reg);
        sts.sum_match   = (rx_byte == running_sum_reg);
        sts.end_match   = (rx_byte == end_byte_reg);
        sts.length_zero = (frame_length_reg == '0);
        sts.out_free    = !out_valid_reg || out_ready;
        sts.drain_last  = (rd_idx_inc == frame_length_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_pos   = out_pos_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

>>> design/stx_length_checksum_frame_parser.sv
// Top level of the start/length/payload/checksum/end frame parser.
//
//  Channel   Dir  Handshake       Payload
//  link      in   valid/ready     rx_byte[7:0]
//  frame     out  valid/ready     payload_byte[7:0], byte_position[5:0], frame_last
//  wr_*      in   wr_en strobe    wr_index[0], wr_data[7:0]
//
// The link is ready in every framing state, so each received byte is taken at
// once. After a good end byte the payload drains from the store byte by byte
// (registered store read, then output register), and the link is held off
// until the last byte is loaded; an output stall extends the drain.
// Reset is asynchronous, active low, and brings the parser to start hunting.
// The last payload byte may wait in the output register while new bytes arrive.
`default_nettype none

module stx_length_checksum_frame_parser
    import stx_lcfp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    stx_lcfp_rx_if.sink            link,
    stx_lcfp_pl_if.source          frame,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_index,
    input  wire logic [BYTE_W-1:0] wr_data
);

    logic    in_ready;
    cmd_t    cmd;
    status_t sts;

    stx_lcfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (link.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stx_lcfp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .rx_byte   (link.rx_byte),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (frame.ready),
        .out_valid (frame.valid),
        .out_byte  (frame.payload_byte),
        .out_pos   (frame.byte_position),
        .out_last  (frame.frame_last)
    );

    assign link.ready = in_ready;

endmodule

`default_nettype wire

>>> design/stx_lcfp_checker.sv
// Port-level checker for the frame parser, bound to the top level.
`default_nettype none

module stx_lcfp_checker
    import stx_lcfp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [BYTE_W-1:0] out_byte,
    input wire logic [POS_W-1:0]  out_pos,
    input wire logic              out_last
);

    logic [POS_W-1:0] exp_pos_reg;

    // Track the position the next item must carry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_pos_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            exp_pos_reg <= out_last ? '0 : (exp_pos_reg + POS_W'(1));
        end
    end

    // Positions count up from zero within each frame
    a_pos_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_pos == exp_pos_reg))
        else $error("payload position out of sequence");

    // Link is held off while a frame is still draining
    a_drain_blocks_link: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |-> !in_ready)
        else $error("link accepted a byte during drain");

    // A stalled item holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)
                                       && $stable(out_pos) && $stable(out_last)))
        else $error("stalled payload item changed");

    // No item during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("payload valid during reset");

endmodule

bind stx_length_checksum_frame_parser stx_lcfp_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (link.ready),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .out_byte  (frame.payload_byte),
    .out_pos   (frame.byte_position),
    .out_last  (frame.frame_last)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the frame parser: directed frames, then random link traffic.
module tb_top;
    import stx_lcfp_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int TARGET_ITEMS  = 310;
    localparam int PHASES        = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 2 * MAX_PAYLOAD + 20;
    localparam int LONG_HOLD     = 400;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int DIR_N         = 27;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              last;
    } pl_item_t;

    // One directed link byte; typed rows carry the single payload byte of a one-byte frame
    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              typed;
        logic [BYTE_W-1:0] pl;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_index;
    logic [BYTE_W-1:0] wr_data;

    stx_lcfp_rx_if link();
    stx_lcfp_pl_if frame();

    stx_length_checksum_frame_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .link     (link),
        .frame    (frame),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Parser model state and register copies
    state_t            parse_state;
    logic [LEN_W-1:0]  frame_len;
    logic [LEN_W-1:0]  taken_cnt;
    logic [BYTE_W-1:0] chk_sum;
    logic [BYTE_W-1:0] pl_store [MAX_PAYLOAD];
    logic [BYTE_W-1:0] start_val;
    logic [BYTE_W-1:0] end_val;

    pl_item_t step_out [$];
    pl_item_t pending_bytes [$];

    int          errors;
    int          bytes_sent;
    int          results_seen;
    int          frames_seen;
    int          reg_writes;
    bit          no_idle;
    bit          long_hold_req;

    // Start byte 02, end byte 03 after reset
    dir_row_t dir_rows [DIR_N] = '{
        '{8'h02, 1'b0, 8'h00},   // start
        '{8'h41, 1'b0, 8'h00},   // length one above the store size: ignored
        '{8'hFF, 1'b0, 8'h00},   // still waiting for a length
        '{8'h01, 1'b0, 8'h00},   // length 1
        '{8'hFF, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 8'h00},   // checksum
        '{8'h03, 1'b1, 8'hFF},   // end: one byte out
        '{8'h02, 1'b0, 8'h00},
        '{8'h00, 1'b0, 8'h00},   // zero length
        '{8'hA5, 1'b0, 8'h00},   // consumed but not summed
        '{8'h00, 1'b0, 8'h00},
        '{8'h03, 1'b0, 8'h00},   // good frame, nothing out
        '{8'h02, 1'b0, 8'h00},
        '{8'h02, 1'b0, 8'h00},   // length 2
        '{8'h10, 1'b0, 8'h00},
        '{8'h20, 1'b0, 8'h00},
        '{8'h02, 1'b0, 8'h00},   // bad checksum equal to start: must not open a frame
        '{8'h02, 1'b0, 8'h00},   // start
        '{8'h01, 1'b0, 8'h00},
        '{8'h00, 1'b0, 8'h00},
        '{8'h00, 1'b0, 8'h00},
        '{8'h03, 1'b1, 8'h00},   // end: one zero byte out
        '{8'h02, 1'b0, 8'h00},
        '{8'h00, 1'b0, 8'h00},
        '{8'h77, 1'b0, 8'h00},
        '{8'h00, 1'b0, 8'h00},
        '{8'h04, 1'b0, 8'h00}    // bad end byte: frame dropped
    };

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // Mostly no gap, often a short one, now and then a long one
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Advance the parser model by one link byte and collect the payload it releases
    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        int unsigned k;
        step_out.delete();
        case (parse_state)
            ST_START:
            begin
                if (b == start_val)
                    parse_state = ST_LENGTH;
            end
            ST_LENGTH:
            begin
                taken_cnt = '0;
                chk_sum   = '0;
                if (b <= MAX_PAYLOAD)
                begin
                    frame_len   = b[LEN_W-1:0];
                    parse_state = ST_FILL;
                end
            end
            ST_FILL:
            begin
                pl_store[(taken_cnt < MAX_PAYLOAD) ? taken_cnt : MAX_PAYLOAD - 1] = b;
                if (taken_cnt < frame_len)
                    chk_sum = chk_sum + b;
                taken_cnt = taken_cnt + 1'b1;
                if (taken_cnt >= frame_len)
                    parse_state = ST_CHECK;
            end
            ST_CHECK:
            begin
                parse_state = (chk_sum == b) ? ST_END : ST_START;
            end
            ST_END:
            begin
                if (b == end_val)
                begin
                    for (k = 0; k < frame_len && k < MAX_PAYLOAD; k++)
                        step_out.push_back('{data: pl_store[k], pos: k[POS_W-1:0],
                                             last: (k + 1 == frame_len)});
                end
                parse_state = ST_START;
            end
            default:
            begin
                parse_state = ST_START;
            end
        endcase
    endtask

    // Offer one item on the link and hold it until taken
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                             input logic [BYTE_W-1:0] typed_pl = 8'h00);
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            link.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        link.valid   <= 1'b1;
        link.rx_byte <= b;
        @(posedge clk);
        while (link.ready !== 1'b1)
            @(posedge clk);
        bytes_sent++;
        parse_byte(b);
        if (typed)
            pending_bytes.push_back('{data: typed_pl, pos: '0, last: 1'b1});
        else
            foreach (step_out[i])
                pending_bytes.push_back(step_out[i]);
    endtask

    // Build one frame from the current start and end bytes
    task automatic send_frame(input int unsigned len, input bit bad_sum, input bit bad_end,
                              input bit oversize);
        logic [BYTE_W-1:0] sum_b;
        logic [BYTE_W-1:0] d;
        sum_b = '0;
        send_byte(start_val);
        if (oversize)
            send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
        send_byte(8'(len));
        if (len == 0)
            send_byte(8'($urandom_range(0, 255)));
        for (int i = 0; i < len; i++)
        begin
            d     = 8'($urandom_range(0, 255));
            sum_b = sum_b + d;
            send_byte(d);
        end
        if (bad_sum)
            sum_b = sum_b + 8'($urandom_range(1, 255));
        send_byte(sum_b);
        send_byte(bad_end ? end_val + 8'($urandom_range(1, 255)) : end_val);
    endtask

    // Mostly well-formed frames, some noise and truncated frames
    task automatic send_random();
        int unsigned r;
        int unsigned len;
        int unsigned cut;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 20)
        begin
            len = $urandom_range(2, 8);
            cut = $urandom_range(0, len - 1);
            send_byte(start_val);
            send_byte(8'(len));
            repeat (cut)
                send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                len = 0;
            else if (r < 15)
                len = MAX_PAYLOAD;
            else if (r < 25)
                len = $urandom_range(9, MAX_PAYLOAD - 1);
            else
                len = $urandom_range(1, 8);
            send_frame(len, $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 8,
                       $urandom_range(0, 99) < 10);
        end
    endtask

    // Write both registers back to back; the link is quiet meanwhile
    task automatic write_regs(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
        wr_en    <= 1'b1;
        wr_index <= REG_START_BYTE;
        wr_data  <= s;
        @(posedge clk);
        wr_index <= REG_END_BYTE;
        wr_data  <= e;
        @(posedge clk);
        wr_en     <= 1'b0;
        start_val  = s;
        end_val    = e;
        reg_writes += 2;
    endtask

    // Stop offering, wait for every pending payload byte, then let the parser settle
    task automatic drain_and_settle();
        link.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_payload();
        pl_item_t want;
        if (pending_bytes.size() == 0)
        begin
            report_mismatch($sformatf("payload byte %02h at position %0d with nothing pending",
                                      frame.payload_byte, frame.byte_position));
            return;
        end
        want = pending_bytes.pop_front();
        results_seen++;
        if (frame.payload_byte !== want.data)
            report_mismatch($sformatf("result %0d: payload_byte %02h, want %02h",
                                      results_seen, frame.payload_byte, want.data));
        if (frame.byte_position !== want.pos)
            report_mismatch($sformatf("result %0d: byte_position %0d, want %0d",
                                      results_seen, frame.byte_position, want.pos));
        if (frame.frame_last !== want.last)
            report_mismatch($sformatf("result %0d: frame_last %b, want %b",
                                      results_seen, frame.frame_last, want.last));
        if (want.last)
            frames_seen++;
    endtask

    // Payload receiver: check each accepted item, stall at random, honor a long hold request
    initial
    begin : payload_sink
        int unsigned stall_left;
        stall_left = 0;
        frame.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (frame.valid === 1'b1 && frame.ready === 1'b1)
                check_payload();
            if (stall_left > 0)
                stall_left--;
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            else
                stall_left = idle_gap();
            frame.ready <= (stall_left == 0) && rst_n;
        end
    end

    initial
    begin : stimulus
        int quota;
        errors        = 0;
        bytes_sent    = 0;
        results_seen  = 0;
        frames_seen   = 0;
        reg_writes    = 0;
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        parse_state   = ST_START;
        frame_len     = '0;
        taken_cnt     = '0;
        chk_sum       = '0;
        start_val     = START_BYTE_RESET;
        end_val       = END_BYTE_RESET;

        rst_n        <= 1'b0;
        wr_en        <= 1'b0;
        wr_index     <= REG_START_BYTE;
        wr_data      <= '0;
        link.valid   <= 1'b0;
        link.rx_byte <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames on the reset register values
        for (int i = 0; i < DIR_N; i++)
            send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].pl);
        drain_and_settle();

        // Random phases, each on its own register setting
        quota = (TARGET_ITEMS - DIR_N) / PHASES;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: write_regs(8'h00, 8'hFF);
                1: write_regs(8'hFF, 8'h00);
                2: write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                3: write_regs(8'h7E, 8'h7E);
                default: write_regs(START_BYTE_RESET, END_BYTE_RESET);
            endcase
            no_idle = (ph == 3);
            // Hold the receiver off while more frames are pushed in
            if (ph == 1)
            begin
                send_frame(12, 1'b0, 1'b0, 1'b0);
                long_hold_req = 1'b1;
            end
            while (bytes_sent < DIR_N + (ph + 1) * quota)
                send_random();
            drain_and_settle();
        end
        no_idle = 1'b0;

        // Catch any stray payload after the last frame
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d link bytes over %0d register writes.", bytes_sent, reg_writes);
        $display("Checked %0d payload bytes in %0d frames.", results_seen, frames_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
